/* rtl/core/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg: shared types and constants for the pulse period tachometer
// Widths, numerator constants, speed unit factors, sequencer types.
// ----------------------------------------------------------------------------
package ppt_pkg;

    // Tick counter width (16..64)
    localparam int COUNT_WIDTH = 32;

    localparam int QUO_W      = 32;
    localparam int STEP_W     = $clog2(QUO_W + 1);
    localparam int CMP_W      = (COUNT_WIDTH > QUO_W) ? COUNT_WIDTH : QUO_W;
    localparam int TIMEOUT_W  = 32;
    localparam int LEN_W      = 30;
    localparam int UNIT_W     = 3;
    localparam int FACTOR_W   = 25;
    localparam int PROD_W     = LEN_W + FACTOR_W;
    // divisor holds up to 100 * count
    localparam int DIV_W      = COUNT_WIDTH + 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [QUO_W-1:0]  QUO_MAX  = {QUO_W{1'b1}};
    localparam logic [PROD_W-1:0] FREQ_NUM = PROD_W'(64'd1000000000);
    localparam logic [PROD_W-1:0] RPM_NUM  = PROD_W'(64'd60000000000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_UNIT = 2'd2;

    // speed unit codes
    localparam logic [UNIT_W-1:0] UNIT_MPS   = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_KMH   = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_MPH   = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_KNOT  = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_FTS   = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_FTMIN = 3'd5;

    typedef enum logic [1:0] {
        DSEL_FREQ,
        DSEL_RPM,
        DSEL_SPEED
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FREQ_GO,
        ST_FREQ_WAIT,
        ST_RPM_GO,
        ST_RPM_WAIT,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic tick;      // tick transaction accepted
        logic pulse;     // ... carrying a pulse
        logic timeout;   // ... raising the stall report
        logic div_done;
        logic out_free;
    } t_seq_in;

    typedef struct packed {
        logic     busy;
        logic     mul_en;
        logic     div_start;
        t_div_sel div_sel;
        logic     quo_we;
        logic     out_we;
    } t_seq_out;

    // unit factor times 1e5; unused codes fall back to m/s
    function automatic logic [FACTOR_W-1:0] unit_factor(input logic [UNIT_W-1:0] code);
        logic [FACTOR_W-1:0] f;
        case (code)
            UNIT_MPS:   f = FACTOR_W'(100000);
            UNIT_KMH:   f = FACTOR_W'(360000);
            UNIT_MPH:   f = FACTOR_W'(223694);
            UNIT_KNOT:  f = FACTOR_W'(194384);
            UNIT_FTS:   f = FACTOR_W'(328084);
            UNIT_FTMIN: f = FACTOR_W'(19685040);
            default:    f = FACTOR_W'(100000);
        endcase
        return f;
    endfunction

    function automatic logic [QUO_W-1:0] sat_period(input logic [COUNT_WIDTH-1:0] p);
        logic [CMP_W-1:0] pe;
        pe = CMP_W'(p);
        if (pe > CMP_W'(QUO_MAX)) begin
            return QUO_MAX;
        end
        return pe[QUO_W-1:0];
    endfunction

endpackage

/* rtl/core/ppt_div.sv */
// ----------------------------------------------------------------------------
// ppt_div: shared serial divider
// Restoring divider, one quotient bit per cycle, quotient saturates at 32 bits.
// ----------------------------------------------------------------------------
module ppt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ppt_pkg::PROD_W-1:0]      i_dividend,
    input  logic [ppt_pkg::DIV_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [ppt_pkg::QUO_W-1:0]       o_quotient
);

    localparam int SAT_W = ppt_pkg::DIV_W + ppt_pkg::QUO_W;

    logic                          r_busy;
    logic                          r_done;
    logic [ppt_pkg::STEP_W-1:0]    r_cnt;
    logic [ppt_pkg::DIV_W-1:0]     r_rem;
    logic [ppt_pkg::DIV_W-1:0]     r_divisor;
    logic [ppt_pkg::QUO_W-1:0]     r_low;
    logic [ppt_pkg::QUO_W-1:0]     r_quo;

    logic                          w_sat;
    logic [ppt_pkg::DIV_W:0]       w_trial;
    logic [ppt_pkg::DIV_W:0]       w_diff;
    logic                          w_ge;

    // quotient would not fit in 32 bits
    assign w_sat   = SAT_W'(i_dividend) >= {i_divisor, {ppt_pkg::QUO_W{1'b0}}};
    assign w_trial = {r_rem, r_low[ppt_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= ppt_pkg::STEP_W'(ppt_pkg::QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ppt_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high part is below the divisor when not saturating
            r_rem     <= ppt_pkg::DIV_W'(i_dividend[ppt_pkg::PROD_W-1:ppt_pkg::QUO_W]);
            r_low     <= i_dividend[ppt_pkg::QUO_W-1:0];
            r_divisor <= i_divisor;
            r_quo     <= w_sat ? ppt_pkg::QUO_MAX : '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[ppt_pkg::DIV_W-1:0] : w_trial[ppt_pkg::DIV_W-1:0];
            r_low <= {r_low[ppt_pkg::QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[ppt_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/ppt_ctrl.sv */
// ----------------------------------------------------------------------------
// ppt_ctrl: result sequencer (a stall report goes straight to output handoff)
// Steps one pulse through product setup, three divisions and output handoff.
// ----------------------------------------------------------------------------
module ppt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppt_pkg::t_seq_in    i_evt,
    output ppt_pkg::t_seq_out   o_ctl
);

    ppt_pkg::t_state r_state;
    ppt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppt_pkg::ST_IDLE: begin
                if (i_evt.tick && i_evt.pulse) begin
                    n_state = ppt_pkg::ST_MUL;
                end else if (i_evt.tick && i_evt.timeout) begin
                    n_state = ppt_pkg::ST_OUT;
                end
            end
            ppt_pkg::ST_MUL:       n_state = ppt_pkg::ST_FREQ_GO;
            ppt_pkg::ST_FREQ_GO:   n_state = ppt_pkg::ST_FREQ_WAIT;
            ppt_pkg::ST_FREQ_WAIT: begin
                if (i_evt.div_done) n_state = ppt_pkg::ST_RPM_GO;
            end
            ppt_pkg::ST_RPM_GO:    n_state = ppt_pkg::ST_RPM_WAIT;
            ppt_pkg::ST_RPM_WAIT: begin
                if (i_evt.div_done) n_state = ppt_pkg::ST_SPD_GO;
            end
            ppt_pkg::ST_SPD_GO:    n_state = ppt_pkg::ST_SPD_WAIT;
            ppt_pkg::ST_SPD_WAIT: begin
                if (i_evt.div_done) n_state = ppt_pkg::ST_OUT;
            end
            ppt_pkg::ST_OUT: begin
                if (i_evt.out_free) n_state = ppt_pkg::ST_IDLE;
            end
            default:               n_state = ppt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl           = '0;
        o_ctl.div_sel   = ppt_pkg::DSEL_FREQ;
        o_ctl.busy      = (r_state != ppt_pkg::ST_IDLE);
        case (r_state)
            ppt_pkg::ST_IDLE:      ;
            ppt_pkg::ST_MUL:       o_ctl.mul_en = 1'b1;
            ppt_pkg::ST_FREQ_GO:   o_ctl.div_start = 1'b1;
            ppt_pkg::ST_FREQ_WAIT: o_ctl.quo_we = i_evt.div_done;
            ppt_pkg::ST_RPM_GO: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel   = ppt_pkg::DSEL_RPM;
            end
            ppt_pkg::ST_RPM_WAIT: begin
                o_ctl.quo_we  = i_evt.div_done;
                o_ctl.div_sel = ppt_pkg::DSEL_RPM;
            end
            ppt_pkg::ST_SPD_GO: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel   = ppt_pkg::DSEL_SPEED;
            end
            ppt_pkg::ST_SPD_WAIT: begin
                o_ctl.quo_we  = i_evt.div_done;
                o_ctl.div_sel = ppt_pkg::DSEL_SPEED;
            end
            ppt_pkg::ST_OUT:       o_ctl.out_we = i_evt.out_free;
            default:               ;
        endcase
    end

endmodule

/* rtl/core/pulse_period_tachometer_top.sv */
// ----------------------------------------------------------------------------
// pulse_period_tachometer_top: period measuring tachometer
// Counts microsecond ticks between pulses and reports period, frequency,
// rpm and speed per pulse, or one stall report per pulse gap.
//
//   channel   direction  handshake               payload
//   tick      in         i_valid / o_stall       i_pulse
//   result    out        o_valid / i_stall       o_period_us .. o_speed_milli
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A tick without a result leaves the sequencer in idle; a stall report goes through output handoff.
// A pulse holds o_stall high through product setup, three passes of the shared
// 32-step divider (a saturating quotient skips the steps) and output handoff.
// Ticks are accepted again once the sequencer is back in idle; a finished
// result waits in the output register while the next ticks come in.
// Synchronous active-low reset restores register defaults and clears the count.
// ----------------------------------------------------------------------------
module pulse_period_tachometer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_pulse,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ppt_pkg::QUO_W-1:0]           o_period_us,
    output logic                                o_stalled,
    output logic [ppt_pkg::QUO_W-1:0]           o_freq_millihz,
    output logic [ppt_pkg::QUO_W-1:0]           o_rpm_milli,
    output logic [ppt_pkg::QUO_W-1:0]           o_speed_milli,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [ppt_pkg::TIMEOUT_W-1:0]      r_timeout_us;
    logic [ppt_pkg::LEN_W-1:0]          r_pulse_length_um;
    logic [ppt_pkg::UNIT_W-1:0]         r_speed_unit;
    logic [ppt_pkg::COUNT_WIDTH-1:0]    r_elapsed_count;
    logic [ppt_pkg::COUNT_WIDTH-1:0]    n_elapsed_count;
    logic                               r_stall_reported;

    logic [ppt_pkg::COUNT_WIDTH-1:0]    r_p;
    logic [ppt_pkg::DIV_W-1:0]          r_p100;
    logic [ppt_pkg::PROD_W-1:0]         r_prod;
    logic [ppt_pkg::QUO_W-1:0]          r_res_period;
    logic                               r_res_stalled;
    logic [ppt_pkg::QUO_W-1:0]          r_res_freq;
    logic [ppt_pkg::QUO_W-1:0]          r_res_rpm;
    logic [ppt_pkg::QUO_W-1:0]          r_res_speed;

    logic                               r_out_valid;
    logic [ppt_pkg::QUO_W-1:0]          r_out_period;
    logic                               r_out_stalled;
    logic [ppt_pkg::QUO_W-1:0]          r_out_freq;
    logic [ppt_pkg::QUO_W-1:0]          r_out_rpm;
    logic [ppt_pkg::QUO_W-1:0]          r_out_speed;

    ppt_pkg::t_seq_in                   w_evt;
    ppt_pkg::t_seq_out                  w_ctl;
    logic                               w_tick;
    logic                               w_timeout;
    logic [ppt_pkg::PROD_W-1:0]         w_dividend;
    logic [ppt_pkg::DIV_W-1:0]          w_divisor;
    logic [ppt_pkg::DIV_W-1:0]          w_p_ext;
    logic                               w_div_done;
    logic [ppt_pkg::QUO_W-1:0]          w_quotient;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_us      <= ppt_pkg::TIMEOUT_W'(1000000);
            r_pulse_length_um <= ppt_pkg::LEN_W'(1000000);
            r_speed_unit      <= ppt_pkg::UNIT_MPS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppt_pkg::CFG_TIMEOUT:    r_timeout_us      <= i_cfg_data;
                ppt_pkg::CFG_PULSE_LEN:  r_pulse_length_um <= i_cfg_data[ppt_pkg::LEN_W-1:0];
                ppt_pkg::CFG_SPEED_UNIT: r_speed_unit      <= i_cfg_data[ppt_pkg::UNIT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ---------------- tick counter ----------------
    assign w_tick          = i_valid && !w_ctl.busy;
    assign o_stall         = w_ctl.busy;
    assign n_elapsed_count = (r_elapsed_count == {ppt_pkg::COUNT_WIDTH{1'b1}}) ?
                             r_elapsed_count : r_elapsed_count + 1'b1;
    assign w_timeout       = !i_pulse && !r_stall_reported &&
                             (ppt_pkg::CMP_W'(n_elapsed_count) >
                              ppt_pkg::CMP_W'(r_timeout_us));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed_count  <= '0;
            r_stall_reported <= 1'b0;
        end else if (w_tick) begin
            r_elapsed_count  <= i_pulse ? '0 : n_elapsed_count;
            if (i_pulse) begin
                r_stall_reported <= 1'b0;
            end else if (w_timeout) begin
                r_stall_reported <= 1'b1;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        w_evt.tick     = w_tick;
        w_evt.pulse    = i_pulse;
        w_evt.timeout  = w_timeout;
        w_evt.div_done = w_div_done;
        w_evt.out_free = !r_out_valid || !i_stall;
    end

    ppt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .o_ctl   (w_ctl)
    );

    // ---------------- operands ----------------
    assign w_p_ext = ppt_pkg::DIV_W'(r_p);

    always_comb begin
        case (w_ctl.div_sel)
            ppt_pkg::DSEL_FREQ: begin
                w_dividend = ppt_pkg::FREQ_NUM;
                w_divisor  = w_p_ext;
            end
            ppt_pkg::DSEL_RPM: begin
                w_dividend = ppt_pkg::RPM_NUM;
                w_divisor  = w_p_ext;
            end
            ppt_pkg::DSEL_SPEED: begin
                // floor(floor(len*K/100)/p) == floor(len*K/(100*p))
                w_dividend = r_prod;
                w_divisor  = r_p100;
            end
            default: begin
                w_dividend = ppt_pkg::FREQ_NUM;
                w_divisor  = w_p_ext;
            end
        endcase
    end

    ppt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_ctl.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // ---------------- result staging ----------------
    always_ff @(posedge i_clk) begin
        if (w_tick && i_pulse) begin
            r_p           <= n_elapsed_count;
            r_res_period  <= ppt_pkg::sat_period(n_elapsed_count);
            r_res_stalled <= 1'b0;
        end else if (w_tick && w_timeout) begin
            r_res_period  <= '0;
            r_res_stalled <= 1'b1;
            r_res_freq    <= '0;
            r_res_rpm     <= '0;
            r_res_speed   <= '0;
        end
        if (w_ctl.mul_en) begin
            r_prod <= ppt_pkg::PROD_W'(r_pulse_length_um) *
                      ppt_pkg::PROD_W'(ppt_pkg::unit_factor(r_speed_unit));
            r_p100 <= (w_p_ext << 6) + (w_p_ext << 5) + (w_p_ext << 2);
        end
        if (w_ctl.quo_we) begin
            case (w_ctl.div_sel)
                ppt_pkg::DSEL_FREQ:  r_res_freq  <= w_quotient;
                ppt_pkg::DSEL_RPM:   r_res_rpm   <= w_quotient;
                ppt_pkg::DSEL_SPEED: r_res_speed <= w_quotient;
                default:             ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_we) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_we) begin
            r_out_period  <= r_res_period;
            r_out_stalled <= r_res_stalled;
            r_out_freq    <= r_res_freq;
            r_out_rpm     <= r_res_rpm;
            r_out_speed   <= r_res_speed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_period_us    = r_out_period;
    assign o_stalled      = r_out_stalled;
    assign o_freq_millihz = r_out_freq;
    assign o_rpm_milli    = r_out_rpm;
    assign o_speed_milli  = r_out_speed;

    // ---------------- assertions ----------------
    a_pulse_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick && i_pulse |=> r_elapsed_count == '0)
        else $error("count not restarted after pulse");

    a_stall_zero_rates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stalled |-> o_period_us == '0 && o_freq_millihz == '0 &&
        o_rpm_milli == '0 && o_speed_milli == '0)
        else $error("stall result with nonzero fields");

    a_pulse_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stalled |-> o_period_us != '0)
        else $error("pulse result with zero period");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.out_we |-> !r_out_valid || !i_stall)
        else $error("output register overwritten while stalled");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: pulse period tachometer testbench
// Sends microsecond tick transactions, some carrying a pulse, under several
// register settings, predicts each period and stall reading in a scoreboard
// and checks every result transaction against it, field by field.
// ----------------------------------------------------------------------------
module tb;
    import ppt_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 200;   // covers one full pulse pass
    localparam int          IDLE_PCT      = 14;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_TICKS   = 65;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [QUO_W-1:0] period_us;
        logic             stalled;
        logic [QUO_W-1:0] freq_millihz;
        logic [QUO_W-1:0] rpm_milli;
        logic [QUO_W-1:0] speed_milli;
    } tach_reading_t;

    class tach_scoreboard;
        logic [TIMEOUT_W-1:0]   timeout_us;
        logic [LEN_W-1:0]       pulse_len_um;
        logic [UNIT_W-1:0]      unit_code;
        logic [COUNT_WIDTH-1:0] elapsed;
        bit                     stall_seen;
        tach_reading_t          expected_readings[$];
        int                     errors;
        int                     pulse_readings;
        int                     stall_reports;

        function new();
            timeout_us     = 32'd1000000;
            pulse_len_um   = 30'd1000000;
            unit_code      = UNIT_MPS;
            elapsed        = '0;
            stall_seen     = 1'b0;
            errors         = 0;
            pulse_readings = 0;
            stall_reports  = 0;
        endfunction

        // unit factor times 1e5
        function logic [63:0] speed_scale(logic [UNIT_W-1:0] code);
            case (code)
                UNIT_KMH:   return 64'd360000;
                UNIT_MPH:   return 64'd223694;
                UNIT_KNOT:  return 64'd194384;
                UNIT_FTS:   return 64'd328084;
                UNIT_FTMIN: return 64'd19685040;
                default:    return 64'd100000;  // m/s, also the unused codes
            endcase
        endfunction

        function logic [31:0] clip32(logic [63:0] v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TIMEOUT:    timeout_us   = data[TIMEOUT_W-1:0];
                CFG_PULSE_LEN:  pulse_len_um = data[LEN_W-1:0];
                CFG_SPEED_UNIT: unit_code    = data[UNIT_W-1:0];
                default:        ;  // no register behind this index
            endcase
        endfunction

        function void account_tick(bit pulse);
            logic [63:0]   p;
            logic [63:0]   travel;
            tach_reading_t r;
            if (elapsed != COUNT_SAT) begin
                elapsed = elapsed + 1'b1;
            end
            p = 64'(elapsed);
            if (pulse) begin
                travel         = (64'(pulse_len_um) * speed_scale(unit_code)) / 64'd100;
                r.period_us    = clip32(p);
                r.stalled      = 1'b0;
                r.freq_millihz = clip32(64'd1000000000 / p);
                r.rpm_milli    = clip32(64'd60000000000 / p);
                r.speed_milli  = clip32(travel / p);
                expected_readings.push_back(r);
                elapsed    = '0;
                stall_seen = 1'b0;
            end else if (!stall_seen && p > 64'(timeout_us)) begin
                // one stall report per gap
                stall_seen = 1'b1;
                r          = '0;
                r.stalled  = 1'b1;
                expected_readings.push_back(r);
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
            end
        endtask

        task check_result(tach_reading_t got);
            tach_reading_t want;
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected result period=%0d stalled=%0b",
                                          got.period_us, got.stalled));
                return;
            end
            want = expected_readings.pop_front();
            if (want.stalled) begin
                stall_reports++;
            end else begin
                pulse_readings++;
            end
            check_field("period_us", got.period_us, want.period_us);
            check_field("stalled", 32'(got.stalled), 32'(want.stalled));
            check_field("freq_millihz", got.freq_millihz, want.freq_millihz);
            check_field("rpm_milli", got.rpm_milli, want.rpm_milli);
            check_field("speed_milli", got.speed_milli, want.speed_milli);
        endtask

        task flush_leftovers();
            if (expected_readings.size() != 0) begin
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_readings.size()));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_pulse;
    logic                  o_valid;
    logic                  i_stall;
    logic [QUO_W-1:0]      o_period_us;
    logic                  o_stalled;
    logic [QUO_W-1:0]      o_freq_millihz;
    logic [QUO_W-1:0]      o_rpm_milli;
    logic [QUO_W-1:0]      o_speed_milli;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tach_scoreboard  sb;
    bit              quiet;
    int              tick_count;
    int              setting_count;
    int unsigned     cycle_count;

    pulse_period_tachometer_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pulse        (i_pulse),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_period_us    (o_period_us),
        .o_stalled      (o_stalled),
        .o_freq_millihz (o_freq_millihz),
        .o_rpm_milli    (o_rpm_milli),
        .o_speed_milli  (o_speed_milli),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_tick(input bit pulse);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_pulse <= pulse;
        do @(posedge i_clk); while (o_stall);
        sb.account_tick(pulse);
        tick_count++;
    endtask

    // leaves valid high so back-to-back writes stay continuous
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
    endtask

    task automatic close_writes();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        // a tick without a result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] timeout_val, input logic [31:0] len_val,
                             input logic [31:0] unit_val);
        wait_drained();
        write_reg(CFG_TIMEOUT, timeout_val);
        write_reg(CFG_PULSE_LEN, len_val);
        write_reg(CFG_SPEED_UNIT, unit_val);
        close_writes();
        setting_count++;
    endtask

    task automatic run_random_phase();
        logic [31:0] timeout_val;
        logic [31:0] len_val;
        logic [31:0] unit_val;
        int          pulse_pct;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            timeout_val = $urandom_range(1, 60);
        end else if (pick < 9) begin
            timeout_val = $urandom();
        end else begin
            timeout_val = 32'hFFFF_FFFF;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            len_val = $urandom_range(1, 1000000000);
        end else if (pick == 6) begin
            len_val = 32'd1;
        end else if (pick == 7) begin
            len_val = 32'd1000000000;
        end else begin
            len_val = $urandom();  // upper bits fall outside the register
        end
        unit_val = {($urandom_range(0, 3) == 0) ? 29'($urandom()) : 29'd0,
                    3'($urandom_range(0, 7))};
        case ($urandom_range(0, 2))
            0:       pulse_pct = 50;
            1:       pulse_pct = 15;
            default: pulse_pct = 4;
        endcase
        configure(timeout_val, len_val, unit_val);
        repeat (PHASE_TICKS) send_tick($urandom_range(0, 99) < pulse_pct);
    endtask

    // result side: random backpressure, check on every accepted transaction
    initial begin
        tach_reading_t got;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got = {o_period_us, o_stalled, o_freq_millihz, o_rpm_milli, o_speed_milli};
                sb.check_result(got);
            end
            i_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        sb            = new();
        quiet         = 1'b0;
        tick_count    = 0;
        setting_count = 0;
        cycle_count   = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pulse     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: first period counts from reset, then period of one
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);

        // zero timeout, zero length, unused unit code
        configure(32'd0, 32'd0, 32'd7);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // pulse on the timeout tick wins, then a single stall per gap
        configure(32'd3, 32'd1000000000, 32'(UNIT_FTMIN));
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        send_tick(1'b1);

        // timeout at the top of the count range never fires
        configure(32'hFFFF_FFFF, 32'd1, 32'd6);
        wait_drained();
        write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
        close_writes();
        send_tick(1'b0);
        send_tick(1'b1);

        for (int u = 1; u <= 4; u++) begin
            configure(32'hFFFF_FFFF, 32'd123456789, 32'(u));
            send_tick(1'b0);
            send_tick(1'b1);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            quiet = (ph == 4) || (ph == 5);
            run_random_phase();
        end
        quiet = 1'b0;

        wait_drained();
        sb.flush_leftovers();
        $display("covered %0d ticks under %0d register settings", tick_count, setting_count);
        $display("checked %0d pulse readings and %0d stall reports, %0d mismatches",
                 sb.pulse_readings, sb.stall_reports, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
